// ----- design/pressure_temperature_compensation_defines.svh -----
// Assertion shorthands used by the checker file.
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_DEFINES_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_DEFINES_SVH

// Same-cycle implication, quiet while in reset
`define PTC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet while in reset
`define PTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/ptc_pkg.sv -----
package ptc_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_TEMP_CAL  = 2'd0;
    localparam logic [1:0] REG_PRESS_LO  = 2'd1;
    localparam logic [1:0] REG_PRESS_HI  = 2'd2;
    localparam logic [1:0] REG_PRESS_P9  = 2'd3;

    localparam int unsigned DIV_W = 64;

    // Unpacked calibration coefficients
    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } cal_t;

    // Data that rides alongside the divider
    typedef struct packed {
        logic [31:0] temp;
        logic        nz;
        logic        neg;
    } side_t;

    // Signed division by 2^k, truncating toward zero
    function automatic logic [31:0] sdiv32_pow2(input logic [31:0] x, input int unsigned k);
        logic [31:0] bias;
        logic [31:0] s;
        bias = x[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
        s = x + bias;
        return 32'($signed(s) >>> k);
    endfunction

    function automatic logic [63:0] sdiv64_pow2(input logic [63:0] x, input int unsigned k);
        logic [63:0] bias;
        logic [63:0] s;
        bias = x[63] ? ((64'd1 << k) - 64'd1) : 64'd0;
        s = x + bias;
        return 64'($signed(s) >>> k);
    endfunction

endpackage

// ----- design/ptc_front.sv -----
module ptc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_vld,
    input  logic [19:0]         raw_t,
    input  logic [19:0]         raw_p,
    input  ptc_pkg::cal_t       cal,
    output logic                out_vld,
    output logic [63:0]         out_num,
    output logic [63:0]         out_den,
    output ptc_pkg::side_t      out_side
);

    logic [10:0] vld_reg;

    logic [31:0] f1_am_reg, f1_bb_reg;
    logic [19:0] f1_p_reg, f2_p_reg, f3_p_reg, f4_p_reg, f5_p_reg, f6_p_reg, f7_p_reg, f8_p_reg;
    logic [31:0] f2_a_reg, f2_bq_reg, f3_a_reg, f3_bm_reg, f4_fine_reg;
    logic [31:0] f5_t_reg, f6_t_reg, f7_t_reg, f8_t_reg, f9_t_reg, f10_t_reg, f11_t_reg;
    logic [63:0] f5_sq_reg;
    logic [48:0] f5_m5_reg, f5_m2_reg, f6_m5_reg, f6_m2_reg;
    logic [63:0] f6_m6_reg, f6_m3_reg, f7_v2_reg, f7_v1_reg, f8_v2_reg, f8_dv_reg;
    logic [63:0] f9_d_reg, f9_n_reg, f10_d_reg, f10_n_reg, f11_num_reg, f11_den_reg;
    logic        f11_nz_reg, f11_neg_reg;

    logic signed [17:0] a0, b0;
    logic signed [33:0] am_full;
    logic signed [35:0] bb_full;
    logic signed [47:0] bm_full;
    logic        [31:0] lin;
    logic signed [32:0] v1;
    logic signed [65:0] sq_full;
    logic signed [48:0] m5_full, m2_full;
    logic signed [79:0] m6_full, m3_full;
    logic signed [80:0] dv_full;
    logic        [20:0] v4;

    // Temperature products and pressure front terms
    always_comb
    begin
        a0      = $signed({1'b0, raw_t[19:3]}) - $signed({1'b0, cal.t1, 1'b0});
        b0      = $signed({2'b00, raw_t[19:4]}) - $signed({2'b00, cal.t1});
        am_full = a0 * cal.t2;
        bb_full = b0 * b0;
        bm_full = $signed(f2_bq_reg) * cal.t3;
        lin     = f4_fine_reg * 32'd5 + 32'd128;
        v1      = $signed({f4_fine_reg[31], f4_fine_reg}) - 33'sd128000;
        sq_full = v1 * v1;
        m5_full = v1 * cal.p5;
        m2_full = v1 * cal.p2;
        m6_full = $signed(f5_sq_reg) * cal.p6;
        m3_full = $signed(f5_sq_reg) * cal.p3;
        dv_full = $signed(f7_v1_reg + 64'h0000_8000_0000_0000) * $signed({1'b0, cal.p1});
        v4      = 21'h10_0000 - {1'b0, f8_p_reg};
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[9:0], in_vld};
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_am_reg   <= am_full[31:0];
            f1_bb_reg   <= bb_full[31:0];
            f1_p_reg    <= raw_p;

            f2_a_reg    <= ptc_pkg::sdiv32_pow2(f1_am_reg, 11);
            f2_bq_reg   <= ptc_pkg::sdiv32_pow2(f1_bb_reg, 12);
            f2_p_reg    <= f1_p_reg;

            f3_a_reg    <= f2_a_reg;
            f3_bm_reg   <= bm_full[31:0];
            f3_p_reg    <= f2_p_reg;

            f4_fine_reg <= f3_a_reg + ptc_pkg::sdiv32_pow2(f3_bm_reg, 14);
            f4_p_reg    <= f3_p_reg;

            f5_t_reg    <= ptc_pkg::sdiv32_pow2(lin, 8);
            f5_sq_reg   <= sq_full[63:0];
            f5_m5_reg   <= m5_full;
            f5_m2_reg   <= m2_full;
            f5_p_reg    <= f4_p_reg;

            f6_t_reg    <= f5_t_reg;
            f6_m6_reg   <= m6_full[63:0];
            f6_m3_reg   <= m3_full[63:0];
            f6_m5_reg   <= f5_m5_reg;
            f6_m2_reg   <= f5_m2_reg;
            f6_p_reg    <= f5_p_reg;

            f7_t_reg    <= f6_t_reg;
            f7_v2_reg   <= f6_m6_reg + ({{15{f6_m5_reg[48]}}, f6_m5_reg} << 17)
                         + ({{48{cal.p4[15]}}, cal.p4} << 35);
            f7_v1_reg   <= ptc_pkg::sdiv64_pow2(f6_m3_reg, 8)
                         + ({{15{f6_m2_reg[48]}}, f6_m2_reg} << 12);
            f7_p_reg    <= f6_p_reg;

            f8_t_reg    <= f7_t_reg;
            f8_v2_reg   <= f7_v2_reg;
            f8_dv_reg   <= dv_full[63:0];
            f8_p_reg    <= f7_p_reg;

            f9_t_reg    <= f8_t_reg;
            f9_d_reg    <= ptc_pkg::sdiv64_pow2(f8_dv_reg, 33);
            f9_n_reg    <= ({43'd0, v4} << 31) - f8_v2_reg;

            f10_t_reg   <= f9_t_reg;
            f10_d_reg   <= f9_d_reg;
            f10_n_reg   <= f9_n_reg * 64'd3125;

            // Magnitudes and quotient sign for the divider
            f11_t_reg   <= f10_t_reg;
            f11_num_reg <= f10_n_reg[63] ? (64'd0 - f10_n_reg) : f10_n_reg;
            f11_den_reg <= f10_d_reg[63] ? (64'd0 - f10_d_reg) : f10_d_reg;
            f11_neg_reg <= f10_n_reg[63] ^ f10_d_reg[63];
            f11_nz_reg  <= |f10_d_reg;
        end
    end

    assign out_vld       = vld_reg[10];
    assign out_num       = f11_num_reg;
    assign out_den       = f11_den_reg;
    assign out_side.temp = f11_t_reg;
    assign out_side.nz   = f11_nz_reg;
    assign out_side.neg  = f11_neg_reg;

endmodule

// ----- design/ptc_div.sv -----
module ptc_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_vld,
    input  logic [63:0]         in_num,
    input  logic [63:0]         in_den,
    input  ptc_pkg::side_t      in_side,
    output logic                out_vld,
    output logic [63:0]         out_quo,
    output ptc_pkg::side_t      out_side
);

    localparam int unsigned N = ptc_pkg::DIV_W;

    // Stage k holds the state after k quotient bits
    logic                  vld_reg  [1:N];
    logic [63:0]           rem_reg  [1:N-1];
    logic [63:0]           dq_reg   [1:N];
    logic [63:0]           den_reg  [1:N-1];
    ptc_pkg::side_t        side_reg [1:N];

    // Operands seen by each step; the incoming transfer feeds the first
    logic                  vld_in   [0:N-1];
    logic [63:0]           rem_in   [0:N-1];
    logic [63:0]           dq_in    [0:N-1];
    logic [63:0]           den_in   [0:N-1];
    ptc_pkg::side_t        side_in  [0:N-1];
    logic [63:0]           sh       [0:N-1];
    logic [64:0]           trial    [0:N-1];

    // One restoring step per stage: shift in a dividend bit, try a subtract
    always_comb
    begin
        vld_in[0]  = in_vld;
        rem_in[0]  = '0;
        dq_in[0]   = in_num;
        den_in[0]  = in_den;
        side_in[0] = in_side;
        for (int k = 1; k < N; k++)
        begin
            vld_in[k]  = vld_reg[k];
            rem_in[k]  = rem_reg[k];
            dq_in[k]   = dq_reg[k];
            den_in[k]  = den_reg[k];
            side_in[k] = side_reg[k];
        end
        for (int k = 0; k < N; k++)
        begin
            sh[k]    = {rem_in[k][62:0], dq_in[k][63]};
            trial[k] = {1'b0, sh[k]} - {1'b0, den_in[k]};
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= N; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k < N; k++)
            begin
                vld_reg[k+1] <= vld_in[k];
            end
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N - 1; k++)
            begin
                rem_reg[k+1] <= trial[k][64] ? sh[k] : trial[k][63:0];
                den_reg[k+1] <= den_in[k];
            end
            for (int k = 0; k < N; k++)
            begin
                dq_reg[k+1]   <= {dq_in[k][62:0], ~trial[k][64]};
                side_reg[k+1] <= side_in[k];
            end
        end
    end

    assign out_vld  = vld_reg[N];
    assign out_quo  = dq_reg[N];
    assign out_side = side_reg[N];

endmodule

// ----- design/ptc_back.sv -----
module ptc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_vld,
    input  logic [63:0]         in_quo,
    input  ptc_pkg::side_t      in_side,
    input  ptc_pkg::cal_t       cal,
    output logic                out_vld,
    output logic [31:0]         out_temp,
    output logic [31:0]         out_pres,
    output logic                out_pvalid
);

    logic [6:0]     vld_reg;
    ptc_pkg::side_t sd_reg [0:6];
    logic [63:0]    b1_v4_reg, b2_v4_reg, b3_v4_reg, b4_v4_reg;
    logic [63:0]    b2_ll_reg, b2_m8_reg;
    logic [31:0]    b2_lh_reg;
    logic [63:0]    b3_xx_reg, b3_d8_reg, b4_d8_reg, b4_m9_reg;
    logic [63:0]    b5_s_reg, b6_w_reg, b7_h_reg;

    logic [63:0]        x, lh_full, hfin;
    logic signed [79:0] m8_full, m9_full;

    always_comb
    begin
        x       = ptc_pkg::sdiv64_pow2(b1_v4_reg, 13);
        lh_full = {32'd0, x[31:0]} * {32'd0, x[63:32]};
        m8_full = $signed(b1_v4_reg) * cal.p8;
        m9_full = $signed(b3_xx_reg) * cal.p9;
        hfin    = ptc_pkg::sdiv64_pow2(b7_h_reg, 7);
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[5:0], in_vld};
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sd_reg[0] <= in_side;
            for (int i = 1; i < 7; i++)
            begin
                sd_reg[i] <= sd_reg[i-1];
            end

            b1_v4_reg <= in_side.neg ? (64'd0 - in_quo) : in_quo;

            // Split the square into 32-bit partial products
            b2_v4_reg <= b1_v4_reg;
            b2_ll_reg <= {32'd0, x[31:0]} * {32'd0, x[31:0]};
            b2_lh_reg <= lh_full[31:0];
            b2_m8_reg <= m8_full[63:0];

            b3_v4_reg <= b2_v4_reg;
            b3_xx_reg <= b2_ll_reg + {b2_lh_reg[30:0], 1'b0, 32'd0};
            b3_d8_reg <= ptc_pkg::sdiv64_pow2(b2_m8_reg, 19);

            b4_v4_reg <= b3_v4_reg;
            b4_d8_reg <= b3_d8_reg;
            b4_m9_reg <= m9_full[63:0];

            b5_s_reg  <= b4_v4_reg + ptc_pkg::sdiv64_pow2(b4_m9_reg, 25) + b4_d8_reg;

            b6_w_reg  <= ptc_pkg::sdiv64_pow2(b5_s_reg, 8) + ({{48{cal.p7[15]}}, cal.p7} << 4);

            b7_h_reg  <= ptc_pkg::sdiv64_pow2(b6_w_reg, 1) * 64'd100;
        end
    end

    assign out_vld    = vld_reg[6];
    assign out_temp   = sd_reg[6].temp;
    assign out_pvalid = sd_reg[6].nz;
    assign out_pres   = sd_reg[6].nz ? hfin[31:0] : 32'd0;

endmodule

// ----- design/pressure_temperature_compensation.sv -----
// Integer compensation of one raw temperature and one raw pressure reading per
// transfer, in hundredths of a degree and hundredths of a pascal. The block is a
// fully pipelined datapath that takes one transfer every cycle unless a full output
// stalls it; each result passes through 11 front stages, a 64-stage bit-per-stage
// unsigned divider, 7 back stages and the output register. Write calibration
// only while nothing is in flight. A zero pressure divisor gives pressure 0
// with the valid flag in tuser clear.
module pressure_temperature_compensation (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration writes
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // raw_temperature [19:0], raw_pressure [39:20]
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // temperature_centi [31:0], pressure_centi_pa [63:32]
    output logic [0:0]  m_tuser    // pressure_valid [0]
);

    logic [47:0] tcal_reg;
    logic [63:0] pcal_lo_reg, pcal_hi_reg;
    logic [15:0] p9_reg;
    ptc_pkg::cal_t cal;

    logic           en;
    logic           fr_vld, dv_vld, bk_vld, bk_pvalid;
    logic [63:0]    fr_num, fr_den, dv_quo;
    ptc_pkg::side_t fr_side, dv_side;
    logic [31:0]    bk_temp, bk_pres;

    logic        out_vld_reg;
    logic [63:0] out_data_reg;
    logic        out_user_reg;

    // Calibration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tcal_reg    <= '0;
            pcal_lo_reg <= '0;
            pcal_hi_reg <= '0;
            p9_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ptc_pkg::REG_TEMP_CAL: tcal_reg    <= cfg_data[47:0];
                ptc_pkg::REG_PRESS_LO: pcal_lo_reg <= cfg_data;
                ptc_pkg::REG_PRESS_HI: pcal_hi_reg <= cfg_data;
                ptc_pkg::REG_PRESS_P9: p9_reg      <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Unpack coefficients
    always_comb
    begin
        cal.t1 = tcal_reg[15:0];
        cal.t2 = tcal_reg[31:16];
        cal.t3 = tcal_reg[47:32];
        cal.p1 = pcal_lo_reg[15:0];
        cal.p2 = pcal_lo_reg[31:16];
        cal.p3 = pcal_lo_reg[47:32];
        cal.p4 = pcal_lo_reg[63:48];
        cal.p5 = pcal_hi_reg[15:0];
        cal.p6 = pcal_hi_reg[31:16];
        cal.p7 = pcal_hi_reg[47:32];
        cal.p8 = pcal_hi_reg[63:48];
        cal.p9 = p9_reg;
    end

    // Hold the pipeline only when a finished result is stuck behind a full output
    assign en       = !out_vld_reg || m_tready || !bk_vld;
    assign s_tready = en;

    ptc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s_tvalid && s_tready),
        .raw_t    (s_tdata[19:0]),
        .raw_p    (s_tdata[39:20]),
        .cal      (cal),
        .out_vld  (fr_vld),
        .out_num  (fr_num),
        .out_den  (fr_den),
        .out_side (fr_side)
    );

    ptc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (fr_vld),
        .in_num   (fr_num),
        .in_den   (fr_den),
        .in_side  (fr_side),
        .out_vld  (dv_vld),
        .out_quo  (dv_quo),
        .out_side (dv_side)
    );

    ptc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_vld     (dv_vld),
        .in_quo     (dv_quo),
        .in_side    (dv_side),
        .cal        (cal),
        .out_vld    (bk_vld),
        .out_temp   (bk_temp),
        .out_pres   (bk_pres),
        .out_pvalid (bk_pvalid)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || m_tready)
        begin
            out_vld_reg <= bk_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || m_tready)
        begin
            out_data_reg <= {bk_pres, bk_temp};
            out_user_reg <= bk_pvalid;
        end
    end

    assign m_tvalid   = out_vld_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_user_reg;

endmodule

// ----- design/ptc_checker.sv -----
`include "pressure_temperature_compensation_defines.svh"

module ptc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [0:0]  m_tuser
);

    `PTC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `PTC_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
    `PTC_ASSERT_NOW(a_zero_pres, m_tvalid && !m_tuser[0], m_tdata[63:32] == 32'd0, "invalid pressure not zero")
    `PTC_ASSERT_NOW(a_ready_cause, !s_tready, m_tvalid && !m_tready, "input held without output stall")

endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- tb/pressure_temperature_compensation_tb.sv -----
module pressure_temperature_compensation_tb;

    typedef struct {
        logic [31:0] temp;
        logic [31:0] press;
        logic        valid;
    } reading_t;

    typedef struct {
        int          phase;
        logic [19:0] raw_t;
        logic [19:0] raw_p;
        bit          known;
        logic [31:0] temp;
        logic [31:0] press;
        logic        valid;
    } stim_row_t;

    localparam int NUM_PHASES = 7;
    localparam int RANDOM_PER_PHASE = 190;
    localparam int DRAIN_CYCLES = 100;
    localparam int IDLE_LIMIT = 5000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // raw_temperature [19:0], raw_pressure [39:20]
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // temperature_centi [31:0], pressure_centi_pa [63:32]
    logic [0:0]  m_tuser;   // pressure_valid [0]

    // Calibration copy held by the predictor
    logic [47:0] cal_temp;
    logic [63:0] cal_press_lo;
    logic [63:0] cal_press_hi;
    logic [15:0] cal_p9;

    reading_t    pending_readings[$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          burst_left;
    int          ready_pct = 100;
    int          ready_hold = 0;

    stim_row_t   stim_table[12] = '{
        '{0, 20'h00000, 20'h00000, 1'b1, 32'd0, 32'd0, 1'b0},
        '{0, 20'hFFFFF, 20'hFFFFF, 1'b1, 32'd0, 32'd0, 1'b0},
        '{0, 20'h00000, 20'hFFFFF, 1'b1, 32'd0, 32'd0, 1'b0},
        '{0, 20'hFFFFF, 20'h00000, 1'b1, 32'd0, 32'd0, 1'b0},
        '{0, 20'h80000, 20'h80000, 1'b1, 32'd0, 32'd0, 1'b0},
        '{0, 20'hAAAAA, 20'h55555, 1'b1, 32'd0, 32'd0, 1'b0},
        '{1, 20'd519888, 20'd415148, 1'b0, 32'd0, 32'd0, 1'b0},
        '{1, 20'h00000, 20'h00000, 1'b0, 32'd0, 32'd0, 1'b0},
        '{1, 20'hFFFFF, 20'hFFFFF, 1'b0, 32'd0, 32'd0, 1'b0},
        '{1, 20'h00000, 20'hFFFFF, 1'b0, 32'd0, 32'd0, 1'b0},
        '{1, 20'hFFFFF, 20'h00000, 1'b0, 32'd0, 32'd0, 1'b0},
        '{1, 20'h55555, 20'hAAAAA, 1'b0, 32'd0, 32'd0, 1'b0}
    };

    pressure_temperature_compensation DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 clk = ~clk;

    // Signed quotients truncated toward zero; the minimum over minus one wraps
    function automatic logic [31:0] quot32(input logic [31:0] num, input logic [31:0] den);
        logic [31:0] mn;
        logic [31:0] md;
        logic [31:0] q;
        if (den == 32'd0)
            return 32'd0;
        mn = num[31] ? -num : num;
        md = den[31] ? -den : den;
        q = mn / md;
        return (num[31] ^ den[31]) ? -q : q;
    endfunction

    function automatic logic [63:0] quot64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] mn;
        logic [63:0] md;
        logic [63:0] q;
        if (den == 64'd0)
            return 64'd0;
        mn = num[63] ? -num : num;
        md = den[63] ? -den : den;
        q = mn / md;
        return (num[63] ^ den[63]) ? -q : q;
    endfunction

    function automatic logic [63:0] ext16(input logic [15:0] x);
        return {{48{x[15]}}, x};
    endfunction

    // Compensated reading for one raw sample pair under the current calibration
    function automatic reading_t compensate(input logic [19:0] raw_t, input logic [19:0] raw_p);
        reading_t    r;
        logic [31:0] adc_t;
        logic [31:0] t1;
        logic [31:0] t2;
        logic [31:0] t3;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] fine;
        logic [63:0] p1;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] v4;
        logic [63:0] q;
        adc_t = {12'd0, raw_t};
        t1 = {16'd0, cal_temp[15:0]};
        t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
        t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
        a = (adc_t >> 3) - (t1 << 1);
        a = quot32(a * t2, 32'd2048);
        b = (adc_t >> 4) - t1;
        b = quot32(quot32(b * b, 32'd4096) * t3, 32'd16384);
        fine = a + b;
        r.temp = quot32(fine * 32'd5 + 32'd128, 32'd256);

        p1 = {48'd0, cal_press_lo[15:0]};
        v1 = {{32{fine[31]}}, fine} - 64'd128000;
        v2 = v1 * v1 * ext16(cal_press_hi[31:16]);
        v2 = v2 + v1 * ext16(cal_press_hi[15:0]) * 64'd131072;
        v2 = v2 + ext16(cal_press_lo[63:48]) * 64'd34359738368;
        v1 = quot64(v1 * v1 * ext16(cal_press_lo[47:32]), 64'd256)
             + v1 * ext16(cal_press_lo[31:16]) * 64'd4096;
        v1 = quot64((64'd140737488355328 + v1) * p1, 64'd8589934592);
        r.press = 32'd0;
        r.valid = 1'b0;
        if (v1 != 64'd0)
        begin
            v4 = 64'd1048576 - {44'd0, raw_p};
            v4 = quot64((v4 * 64'd2147483648 - v2) * 64'd3125, v1);
            q = quot64(v4, 64'd8192);
            v1 = quot64(ext16(cal_p9) * q * q, 64'd33554432);
            v2 = quot64(ext16(cal_press_hi[63:48]) * v4, 64'd524288);
            v4 = quot64(v4 + v1 + v2, 64'd256) + ext16(cal_press_hi[47:32]) * 64'd16;
            q = quot64(quot64(v4, 64'd2) * 64'd100, 64'd128);
            r.press = q[31:0];
            r.valid = 1'b1;
        end
        return r;
    endfunction

    // Write one calibration register and mirror it
    task automatic write_cal(input logic [1:0] idx, input logic [63:0] value);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        case (idx)
            ptc_pkg::REG_TEMP_CAL: cal_temp = value[47:0];
            ptc_pkg::REG_PRESS_LO: cal_press_lo = value;
            ptc_pkg::REG_PRESS_HI: cal_press_hi = value;
            ptc_pkg::REG_PRESS_P9: cal_p9 = value[15:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic load_phase_cal(input int phase);
        logic [63:0] upper;
        upper = {$urandom, $urandom};
        case (phase)
            0:
            begin
                write_cal(ptc_pkg::REG_TEMP_CAL, {upper[63:48], 48'd0});
                write_cal(ptc_pkg::REG_PRESS_LO, 64'd0);
                write_cal(ptc_pkg::REG_PRESS_HI, 64'd0);
                write_cal(ptc_pkg::REG_PRESS_P9, {upper[63:16], 16'd0});
            end
            1:
            begin
                write_cal(ptc_pkg::REG_TEMP_CAL, {16'd0, 16'hFC18, 16'd26435, 16'd27504});
                write_cal(ptc_pkg::REG_PRESS_LO, {16'd2855, 16'd3024, 16'hD643, 16'd36477});
                write_cal(ptc_pkg::REG_PRESS_HI, {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140});
                write_cal(ptc_pkg::REG_PRESS_P9, 64'd6000);
            end
            2:
            begin
                write_cal(ptc_pkg::REG_TEMP_CAL, {64{1'b1}});
                write_cal(ptc_pkg::REG_PRESS_LO, {64{1'b1}});
                write_cal(ptc_pkg::REG_PRESS_HI, {64{1'b1}});
                write_cal(ptc_pkg::REG_PRESS_P9, {64{1'b1}});
            end
            3:
            begin
                write_cal(ptc_pkg::REG_TEMP_CAL, {upper[63:48], {3{16'h8000}}});
                write_cal(ptc_pkg::REG_PRESS_LO, {4{16'h8000}});
                write_cal(ptc_pkg::REG_PRESS_HI, {4{16'h8000}});
                write_cal(ptc_pkg::REG_PRESS_P9, {48'd0, 16'h8000});
            end
            4, 5:
            begin
                // Perturbed typical calibration keeps the pressure path in range
                write_cal(ptc_pkg::REG_TEMP_CAL, {16'd0, 16'(-1000 + $urandom_range(0, 400)),
                                                  16'(26000 + $urandom_range(0, 900)),
                                                  16'(27000 + $urandom_range(0, 1000))});
                write_cal(ptc_pkg::REG_PRESS_LO, {16'(2800 + $urandom_range(0, 100)),
                                                  16'(3000 + $urandom_range(0, 50)),
                                                  16'(-10700 + $urandom_range(0, 30)),
                                                  16'(36000 + $urandom_range(0, 1000))});
                write_cal(ptc_pkg::REG_PRESS_HI, {16'(-14600 + $urandom_range(0, 50)),
                                                  16'(15500 + $urandom_range(0, 50)),
                                                  16'(-7 + $urandom_range(0, 3)),
                                                  16'(140 + $urandom_range(0, 10))});
                write_cal(ptc_pkg::REG_PRESS_P9,
                          {upper[63:16], 16'(6000 + $urandom_range(0, 100))});
            end
            default:
            begin
                write_cal(ptc_pkg::REG_TEMP_CAL, {$urandom, $urandom});
                write_cal(ptc_pkg::REG_PRESS_LO, {$urandom, $urandom});
                write_cal(ptc_pkg::REG_PRESS_HI, {$urandom, $urandom});
                write_cal(ptc_pkg::REG_PRESS_P9, {$urandom, $urandom});
            end
        endcase
    endtask

    // Offer one sample pair, holding it until the transfer; returns at a falling edge
    task automatic send_sample(input logic [19:0] raw_t, input logic [19:0] raw_p,
                               input bit known, input reading_t typed);
        if (burst_left == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 20)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 30);
        end
        s_tvalid = 1'b1;
        s_tdata = {raw_p, raw_t};
        do
            @(posedge clk);
        while (!s_tready);
        pending_readings.push_back(known ? typed : compensate(raw_t, raw_p));
        burst_left--;
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        wait (pending_readings.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [19:0] pick_raw();
        case ($urandom_range(0, 5))
            0: return 20'h00000;
            1: return 20'hFFFFF;
            2: return 20'(300000 + $urandom_range(0, 300000));
            default: return 20'($urandom);
        endcase
    endfunction

    // Receiver stall pattern: ready density is redrawn whenever its hold count runs out
    always @(negedge clk)
    begin
        if (ready_hold == 0)
        begin
            case ($urandom_range(0, 3))
                0: ready_pct = 100;
                1: ready_pct = 80;
                2: ready_pct = 40;
                default: ready_pct = 10;
            endcase
            ready_hold = $urandom_range(50, 300);
        end
        ready_hold--;
        m_tready <= ($urandom_range(0, 99) < ready_pct);
    end

    // Compare each result transfer with the oldest expected reading
    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_readings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: temp %0d press %0d valid %0d",
                             $signed(m_tdata[31:0]), m_tdata[63:32], m_tuser[0]);
            end
            else
            begin
                want = pending_readings.pop_front();
                if (m_tdata[31:0] !== want.temp || m_tdata[63:32] !== want.press
                    || m_tuser[0] !== want.valid)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected temp %0d press %0d valid %0d, got temp %0d press %0d valid %0d",
                                 $signed(want.temp), want.press, want.valid,
                                 $signed(m_tdata[31:0]), m_tdata[63:32], m_tuser[0]);
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        reading_t typed;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = ptc_pkg::REG_TEMP_CAL;
        cfg_data = 64'd0;
        s_tvalid = 1'b0;
        s_tdata = 40'd0;
        cal_temp = 48'd0;
        cal_press_lo = 64'd0;
        cal_press_hi = 64'd0;
        cal_p9 = 16'd0;
        burst_left = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Zero calibration out of reset: temperature 0 and no valid pressure
        for (int i = 0; i < 12; i++)
        begin
            if (stim_table[i].phase == 0)
            begin
                typed = '{stim_table[i].temp, stim_table[i].press, stim_table[i].valid};
                send_sample(stim_table[i].raw_t, stim_table[i].raw_p, 1'b1, typed);
            end
        end
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            load_phase_cal(ph);
            for (int i = 0; i < 12; i++)
            begin
                if (stim_table[i].phase == ph && !stim_table[i].known)
                    send_sample(stim_table[i].raw_t, stim_table[i].raw_p, 1'b0, typed);
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                // Hold off mid-phase until the pipeline has emptied
                if (n == RANDOM_PER_PHASE / 2)
                    drain();
                send_sample(pick_raw(), pick_raw(), 1'b0, typed);
            end
            drain();
        end

        if (mismatches == 0 && pending_readings.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+design
design/ptc_pkg.sv
design/ptc_front.sv
design/ptc_div.sv
design/ptc_back.sv
design/pressure_temperature_compensation.sv
design/ptc_checker.sv
tb/pressure_temperature_compensation_tb.sv
